@@ sv/dwp_pkg.sv @@
// ----------------------------------------------------------------------------
// Draw pool package
// Shared widths, operation codes and the default pool size of the draw pool.
// ----------------------------------------------------------------------------
package dwp_pkg;

   localparam int CODE_W        = 6;
   localparam int RND_W         = 16;
   localparam int OP_W          = 2;
   localparam int POOL_SIZE_DEF = 52;

   typedef enum logic [OP_W-1:0] {
      OP_RANDOM   = 2'd0,
      OP_SPECIFIC = 2'd1,
      OP_SHUFFLE  = 2'd2,
      OP_RESET    = 2'd3
   } op_type;

endpackage

@@ sv/dwp_req_if.sv @@
// ----------------------------------------------------------------------------
// Draw pool request channel
// Valid/ready channel that carries one operation word into the pool.
// ----------------------------------------------------------------------------
interface dwp_req_if;
   import dwp_pkg::*;

   logic                valid;
   logic                ready;
   op_type              operation;
   logic [RND_W-1:0]    random_value;
   logic [CODE_W-1:0]   wanted_code;

   modport source (output valid, operation, random_value, wanted_code, input ready);
   modport sink (input valid, operation, random_value, wanted_code, output ready);

endinterface

@@ sv/dwp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Draw pool response channel
// Valid/ready channel that carries one result word out of the pool.
// ----------------------------------------------------------------------------
interface dwp_rsp_if;
   import dwp_pkg::*;

   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   item_code;
   logic                found;
   logic [CODE_W-1:0]   remaining;

   modport source (output valid, item_code, found, remaining, input ready);
   modport sink (input valid, item_code, found, remaining, output ready);

endinterface

@@ sv/draw_without_replacement_pool.sv @@
// Random draw: remainder unit, then a swap of the picked slot and the last undrawn one.
// Specific draw: a one-slot-per-cycle search, then a swap with the last undrawn slot.
// Shuffle: the drawn count is cleared. Reset order: also the identity refill.
// One word is in work at a time; the next is taken while a result waits.
// After reset the slot memory is refilled before the first accept.
// ----------------------------------------------------------------------------
// Draw without replacement pool
// Fisher-Yates style draw from a pool of item codes kept in a slot memory,
// run by a small sequencer around one remainder unit.
// ----------------------------------------------------------------------------
module draw_without_replacement_pool #(
   parameter int POOL_SIZE = dwp_pkg::POOL_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dwp_req_if.sink    req_ch,
   dwp_rsp_if.source  rsp_ch
);
   import dwp_pkg::*;

   localparam int CW = $clog2(POOL_SIZE + 1);
   localparam int AW = $clog2(POOL_SIZE);

   typedef enum logic [8:0] {
      S_INIT = 9'b000000001,
      S_IDLE = 9'b000000010,
      S_DIV  = 9'b000000100,
      S_SRCH = 9'b000001000,
      S_RDA  = 9'b000010000,
      S_RDL  = 9'b000100000,
      S_WRA  = 9'b001000000,
      S_WRB  = 9'b010000000,
      S_RESP = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [CODE_W-1:0]  want_ff, want_in;
   logic [CW-1:0]      drawn_ff, drawn_in;
   logic [CW-1:0]      left_ff, left_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               cmp_v_ff, cmp_v_in;
   logic [CW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               hit_ff, hit_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [CODE_W-1:0]  rsp_rem_ff, rsp_rem_in;

   logic [CW-1:0]      pool_n;
   logic [CW-1:0]      drawn_eff;
   logic [CW-1:0]      rand_left;
   logic [CW-1:0]      last;
   logic               issue;
   logic               match;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [CODE_W-1:0]  ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [CODE_W-1:0]  ram_rdata;

   logic               rem_start;
   logic               rem_done;
   logic [CW-1:0]      rem_value;

   assign pool_n    = CW'(POOL_SIZE);
   assign drawn_eff = (drawn_ff >= pool_n) ? '0 : drawn_ff;
   assign rand_left = pool_n - drawn_eff;
   assign last      = left_ff - 1'b1;
   assign issue     = idx_ff < left_ff;
   assign match     = cmp_v_ff && (ram_rdata == want_ff);

   dwp_rem #(
      .DIV_W (CW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_ch.random_value),
      .divisor   (rand_left),
      .done      (rem_done),
      .remainder (rem_value)
   );

   dwp_ram #(
      .DEPTH (POOL_SIZE),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      want_in      = want_ff;
      drawn_in     = drawn_ff;
      left_in      = left_ff;
      idx_in       = idx_ff;
      cmp_v_in     = cmp_v_ff;
      cmp_idx_in   = cmp_idx_ff;
      code_in      = code_ff;
      hit_in       = hit_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_found_in = rsp_found_ff;
      rsp_rem_in   = rsp_rem_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[AW-1:0];
      ram_wdata    = code_ff;
      ram_raddr    = idx_ff[AW-1:0];
      rem_start    = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = CODE_W'(idx_ff);
            if (idx_ff == pool_n - 1'b1) begin
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = pend_ff ? S_RESP : S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in   = req_ch.operation;
               want_in = req_ch.wanted_code;
               hit_in  = 1'b0;
               code_in = '0;
               case (req_ch.operation)
                  OP_RANDOM: begin
                     drawn_in  = drawn_eff;
                     left_in   = rand_left;
                     rem_start = 1'b1;
                     state_in  = S_DIV;
                  end
                  OP_SPECIFIC: begin
                     left_in  = pool_n - drawn_ff;
                     idx_in   = '0;
                     cmp_v_in = 1'b0;
                     state_in = (drawn_ff == pool_n) ? S_RESP : S_SRCH;
                  end
                  OP_SHUFFLE: begin
                     drawn_in = '0;
                     state_in = S_RESP;
                  end
                  default: begin
                     drawn_in = '0;
                     idx_in   = '0;
                     pend_in  = 1'b1;
                     state_in = S_INIT;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (rem_done) begin
               idx_in   = rem_value;
               state_in = S_RDA;
            end
         end
         S_SRCH: begin
            cmp_v_in   = issue;
            cmp_idx_in = idx_ff;
            if (match) begin
               idx_in   = cmp_idx_ff;
               code_in  = want_ff;
               state_in = S_RDL;
            end else if (!issue) begin
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RDA: begin
            state_in = S_RDL;
         end
         S_RDL: begin
            ram_raddr = last[AW-1:0];
            if (op_ff == OP_RANDOM) begin
               code_in = ram_rdata;
            end
            state_in = S_WRA;
         end
         S_WRA: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            state_in  = S_WRB;
         end
         S_WRB: begin
            ram_we    = 1'b1;
            ram_waddr = last[AW-1:0];
            drawn_in  = drawn_ff + 1'b1;
            hit_in    = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
               rsp_found_in = hit_ff;
               rsp_rem_in   = CODE_W'(pool_n - drawn_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         drawn_ff     <= '0;
         idx_ff       <= '0;
         cmp_v_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drawn_ff     <= drawn_in;
         idx_ff       <= idx_in;
         cmp_v_ff     <= cmp_v_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      want_ff      <= want_in;
      left_ff      <= left_in;
      cmp_idx_ff   <= cmp_idx_in;
      code_ff      <= code_in;
      hit_ff       <= hit_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_found_ff <= rsp_found_in;
      rsp_rem_ff   <= rsp_rem_in;
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.item_code = rsp_code_ff;
   assign rsp_ch.found     = rsp_found_ff;
   assign rsp_ch.remaining = rsp_rem_ff;

   // The drawn count never runs past the pool size.
   assert property (@(posedge clock) disable iff (reset) drawn_ff <= pool_n)
      else $error("drawn count exceeds pool size");

   // A random draw always ends with an item drawn.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && op_ff == OP_RANDOM && !pend_ff) |-> hit_ff)
      else $error("random draw finished without an item");

   // The remainder unit reports only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset) rem_done |-> state_ff == S_DIV)
      else $error("remainder result outside of the divide step");

   // The slot memory is never written while a new word can be taken.
   assert property (@(posedge clock) disable iff (reset) (state_ff == S_IDLE) |-> !ram_we)
      else $error("slot memory written while idle");

endmodule

@@ sv/dwp_rem.sv @@
// ----------------------------------------------------------------------------
// Draw pool remainder unit
// Restoring remainder of the random value by the undrawn count, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module dwp_rem #(
   parameter int DIV_W = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [dwp_pkg::RND_W-1:0] dividend,
   input  logic [DIV_W-1:0]          divisor,
   output logic                      done,
   output logic [DIV_W-1:0]          remainder
);
   import dwp_pkg::*;

   localparam int CNT_W = $clog2(RND_W + 1);

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RND_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;

   assign trial = {rem_ff, dvd_ff[RND_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(RND_W);
         dvd_in = dividend;
         div_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIV_W-1:0];
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/dwp_ram.sv @@
// ----------------------------------------------------------------------------
// Draw pool slot memory
// Slot store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dwp_ram #(
   parameter int DEPTH = 52,
   parameter int AW    = 6
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [AW-1:0]              waddr,
   input  logic [dwp_pkg::CODE_W-1:0] wdata,
   input  logic [AW-1:0]              raddr,
   output logic [dwp_pkg::CODE_W-1:0] rdata
);
   import dwp_pkg::*;

   logic [CODE_W-1:0] slot_mem [DEPTH];
   logic [CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         slot_mem[waddr] <= wdata;
      end
      rd_data_ff <= slot_mem[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

@@ verif/draw_without_replacement_pool_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Draw pool testbench
// Drives random, specific, shuffle and reset-order words into the draw pool.
// Each result word is checked against a slot-level model of the pool that
// tracks the undrawn and drawn parts, or against the typed result of a
// directed word. The run covers full deals to exhaustion, short hands and
// noise, under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
module draw_without_replacement_pool_test;
   import dwp_pkg::*;

   localparam int POOL_SIZE   = POOL_SIZE_DEF;
   localparam int ITEM_TARGET = 1650;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DIRECTED_N  = 23;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              hit;
      logic [CODE_W-1:0] left;
   } draw_result;

   typedef struct packed {
      op_type            op;
      logic [RND_W-1:0]  rnd;
      logic [CODE_W-1:0] want;
      logic              typed;
      draw_result        res;
   } stim_row;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dwp_req_if req_bus ();
   dwp_rsp_if rsp_bus ();

   draw_without_replacement_pool #(.POOL_SIZE(POOL_SIZE)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   logic [CODE_W-1:0] slot_model [POOL_SIZE];
   int unsigned       drawn_model;
   draw_result        pending_draws [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                sent_total = 0;
   int                sender_idle_pct = 35;
   int                receiver_idle_pct = 79;

   // Expected results are typed in only where they follow at a glance.
   stim_row directed_rows [DIRECTED_N] = '{
      '{OP_RANDOM,   16'h0000, 6'd0,  1'b1, '{6'd0,  1'b1, 6'd51}},
      '{OP_RANDOM,   16'hFFFF, 6'd63, 1'b0, '0},
      '{OP_SPECIFIC, 16'h0000, 6'd0,  1'b1, '{6'd0,  1'b0, 6'd50}},
      '{OP_SPECIFIC, 16'hFFFF, 6'd63, 1'b1, '{6'd0,  1'b0, 6'd50}},
      '{OP_SPECIFIC, 16'h1234, 6'd5,  1'b1, '{6'd5,  1'b1, 6'd49}},
      '{OP_SPECIFIC, 16'h0000, 6'd51, 1'b1, '{6'd0,  1'b0, 6'd49}},
      '{OP_RANDOM,   16'h5555, 6'd21, 1'b0, '0},
      '{OP_SPECIFIC, 16'hAAAA, 6'd52, 1'b1, '{6'd0,  1'b0, 6'd48}},
      '{OP_SHUFFLE,  16'hFFFF, 6'd63, 1'b1, '{6'd0,  1'b0, 6'd52}},
      '{OP_SPECIFIC, 16'h0000, 6'd0,  1'b1, '{6'd0,  1'b1, 6'd51}},
      '{OP_RANDOM,   16'h8000, 6'd42, 1'b0, '0},
      '{OP_RESET,    16'hFFFF, 6'd63, 1'b1, '{6'd0,  1'b0, 6'd52}},
      '{OP_RANDOM,   16'd51,   6'd0,  1'b1, '{6'd51, 1'b1, 6'd51}},
      '{OP_RANDOM,   16'd52,   6'd0,  1'b1, '{6'd1,  1'b1, 6'd50}},
      '{OP_SPECIFIC, 16'h0000, 6'd50, 1'b0, '0},
      '{OP_SPECIFIC, 16'h00FF, 6'd42, 1'b0, '0},
      '{OP_RANDOM,   16'h7FFF, 6'd10, 1'b0, '0},
      '{OP_RANDOM,   16'hAAAA, 6'd31, 1'b0, '0},
      '{OP_SHUFFLE,  16'h0000, 6'd0,  1'b1, '{6'd0,  1'b0, 6'd52}},
      '{OP_RESET,    16'h0000, 6'd0,  1'b1, '{6'd0,  1'b0, 6'd52}},
      '{OP_SPECIFIC, 16'h0000, 6'd51, 1'b1, '{6'd51, 1'b1, 6'd51}},
      '{OP_SPECIFIC, 16'h0000, 6'd0,  1'b1, '{6'd0,  1'b1, 6'd50}},
      '{OP_RANDOM,   16'hFFFF, 6'd63, 1'b0, '0}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic void restore_identity();
      for (int idx = 0; idx < POOL_SIZE; idx++) begin
         slot_model[idx] = CODE_W'(idx);
      end
      drawn_model = 0;
   endfunction

   function automatic draw_result predict_draw(input op_type op,
                                               input logic [RND_W-1:0] rnd,
                                               input logic [CODE_W-1:0] want);
      draw_result        res;
      int unsigned       span;
      int unsigned       pick;
      int unsigned       idx;
      logic [CODE_W-1:0] held;
      res = '0;
      case (op)
         OP_RANDOM: begin
            if (drawn_model >= POOL_SIZE) drawn_model = 0;
            span = POOL_SIZE - drawn_model;
            pick = rnd % span;
            res.code = slot_model[pick];
            held = slot_model[pick];
            slot_model[pick] = slot_model[span-1];
            slot_model[span-1] = held;
            drawn_model++;
            res.hit = 1'b1;
         end
         OP_SPECIFIC: begin
            span = POOL_SIZE - drawn_model;
            for (idx = 0; idx < span && !res.hit; idx++) begin
               if (slot_model[idx] == want) begin
                  res.code = want;
                  slot_model[idx] = slot_model[span-1];
                  slot_model[span-1] = want;
                  drawn_model++;
                  res.hit = 1'b1;
               end
            end
         end
         OP_SHUFFLE: begin
            drawn_model = 0;
         end
         default: begin
            restore_identity();
         end
      endcase
      res.left = CODE_W'(POOL_SIZE - drawn_model);
      return res;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input op_type op, input logic [RND_W-1:0] rnd,
                            input logic [CODE_W-1:0] want, input logic typed,
                            input draw_result typed_res);
      draw_result res;
      if (sent_total < ITEM_TARGET / 3) begin
         sender_idle_pct = 35;
         receiver_idle_pct = 79;
      end else if (sent_total < 2 * ITEM_TARGET / 3) begin
         sender_idle_pct = 79;
         receiver_idle_pct = 35;
      end else begin
         sender_idle_pct = 0;
         receiver_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.random_value <= rnd;
      req_bus.wanted_code <= want;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      res = predict_draw(op, rnd, want);
      pending_draws.push_back(typed ? typed_res : res);
      sent_total++;
      @(negedge clock);
   endtask

   task automatic send_any(input op_type op, input logic [CODE_W-1:0] want);
      send_word(op, RND_W'($urandom_range(0, 65535)), want, 1'b0, '0);
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      draw_result want_res;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_draws.size() == 0) begin
            report_mismatch("result word with no expectation waiting");
         end else begin
            want_res = pending_draws.pop_front();
            if (rsp_bus.item_code !== want_res.code)
               report_mismatch($sformatf("item_code %0d, expected %0d",
                                         rsp_bus.item_code, want_res.code));
            if (rsp_bus.found !== want_res.hit)
               report_mismatch($sformatf("found %0b, expected %0b",
                                         rsp_bus.found, want_res.hit));
            if (rsp_bus.remaining !== want_res.left)
               report_mismatch($sformatf("remaining %0d, expected %0d",
                                         rsp_bus.remaining, want_res.left));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         report_mismatch("timeout");
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int kind;
      int hand;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_RANDOM;
      req_bus.random_value = '0;
      req_bus.wanted_code = '0;
      restore_identity();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[row]) begin
         send_word(directed_rows[row].op, directed_rows[row].rnd,
                   directed_rows[row].want, directed_rows[row].typed,
                   directed_rows[row].res);
      end

      while (sent_total < ITEM_TARGET) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            // A full deal down to an empty pool, then words on the empty pool.
            while (drawn_model < POOL_SIZE) begin
               hand = $urandom_range(0, 99);
               if (hand < 65)
                  send_any(OP_RANDOM, CODE_W'($urandom_range(0, 63)));
               else if (hand < 92)
                  send_any(OP_SPECIFIC,
                           slot_model[$urandom_range(0, POOL_SIZE - 1 - drawn_model)]);
               else
                  send_any(OP_SPECIFIC, CODE_W'($urandom_range(0, 63)));
            end
            repeat ($urandom_range(1, 3)) begin
               send_any($urandom_range(0, 1) ? OP_SPECIFIC : OP_RANDOM,
                        CODE_W'($urandom_range(0, 63)));
            end
            hand = $urandom_range(0, 9);
            if (hand < 5)
               send_any(OP_SHUFFLE, CODE_W'($urandom_range(0, 63)));
            else if (hand < 8)
               send_any(OP_RESET, CODE_W'($urandom_range(0, 63)));
         end else if (kind < 80) begin
            repeat ($urandom_range(2, 10)) begin
               if ($urandom_range(0, 1) && drawn_model < POOL_SIZE)
                  send_any(OP_SPECIFIC,
                           slot_model[$urandom_range(0, POOL_SIZE - 1 - drawn_model)]);
               else
                  send_any(OP_RANDOM, CODE_W'($urandom_range(0, 63)));
            end
            send_any($urandom_range(0, 1) ? OP_SHUFFLE : OP_RESET,
                     CODE_W'($urandom_range(0, 63)));
         end else begin
            repeat ($urandom_range(1, 5)) begin
               send_any(op_type'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 63)));
            end
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_draws.size() != 0) @(posedge clock);
      repeat (POOL_SIZE + 16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
